/* hdl/pulsar_wavetable_oscillator_defines.svh */
// Assertion macros shared by the pulsar wavetable oscillator RTL.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef PULSAR_WAVETABLE_OSCILLATOR_DEFINES_SVH
`define PULSAR_WAVETABLE_OSCILLATOR_DEFINES_SVH
`ifndef SYNTHESIS
// Antecedent and consequent in the same cycle.
`define PWO_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("pwo: same-cycle check failed");
// Consequent in the cycle after the antecedent.
`define PWO_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pwo: next-cycle check failed");
`else
`define PWO_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define PWO_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/pwo_pkg.sv */
// Types, codes and fixed constants of the pulsar wavetable oscillator.
// No dependencies; imported by every other module of the block but pwo_ram.
`timescale 1ns / 1ps
package pwo_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int REM_NUM_W   = 14;
    localparam int REM_DEN_W   = 13;

    localparam logic [31:0] LFSR_MASK      = 32'h8020_0003;
    localparam logic [16:0] SAT_ALWAYS     = 17'd65536;
    localparam logic signed [15:0] SMAX    = 16'sh7FFF;
    localparam logic signed [15:0] SMIN    = -16'sh8000;

    localparam logic [31:0] RST_PHASE_STEP = 32'd19685266;
    localparam logic [31:0] RST_MORPH_STEP = 32'd10737;
    localparam logic [31:0] RST_SEED       = 32'd1;

    typedef enum logic [2:0] {
        KIND_TICK        = 3'd0,
        KIND_WAVE_SAMPLE = 3'd1,
        KIND_WIN_SAMPLE  = 3'd2,
        KIND_WAVE_DESC   = 3'd3,
        KIND_WIN_DESC    = 3'd4,
        KIND_BURST       = 3'd5,
        KIND_WAVE_TOTAL  = 3'd6,
        KIND_WIN_TOTAL   = 3'd7
    } t_kind;

    typedef enum logic [2:0] {
        REG_PHASE_STEP   = 3'd0,
        REG_WAVE_MSTEP   = 3'd1,
        REG_WIN_MSTEP    = 3'd2,
        REG_SATURATION   = 3'd3,
        REG_WAVE_COUNT   = 3'd4,
        REG_WIN_COUNT    = 3'd5,
        REG_BURST_LENGTH = 3'd6,
        REG_NOISE_SEED   = 3'd7
    } t_reg_idx;

    typedef struct packed {
        logic [2:0]         kind;
        logic [11:0]        address;
        logic signed [15:0] value;
        logic [11:0]        onset;
        logic [12:0]        length;
    } t_in_item;

    typedef struct packed {
        logic signed [15:0] sample;
        logic               pulse_edge;
        logic               pulse_sounded;
    } t_out_item;

    typedef enum logic [4:0] {
        S_IDLE, S_START, S_BDIV, S_BRD, S_BCHK, S_BDEC, S_SIDE, S_MORPH, S_MSAVE,
        S_DREAD, S_DLATCH, S_PMUL, S_PSAVE, S_ADIV, S_SRDA, S_SRDB, S_SLB,
        S_MIXA, S_MIXB, S_MIXC, S_OUTER, S_SDONE, S_WMUL, S_WSAT, S_FIN
    } t_state;

    typedef enum logic [4:0] {
        OP_NONE, OP_IDLE, OP_START, OP_BREAD, OP_BCHK, OP_MORPH, OP_MSAVE,
        OP_DREAD, OP_DLATCH, OP_PMUL, OP_PSAVE, OP_SREADA, OP_SREADB, OP_SLATCHB,
        OP_MIXA, OP_MIXB, OP_MIXC, OP_OUTER, OP_SDONE, OP_WMUL, OP_WSAT, OP_FIN
    } t_op;

    typedef struct packed {
        t_op  op;
        logic side;
        logic second;
    } t_cmd;

    typedef struct packed {
        logic is_tick;
        logic rem_done;
        logic blen_zero;
        logic sounded;
        logic cnt_zero;
        logic cnt_one;
        logic out_free;
    } t_status;

endpackage

/* hdl/pwo_ram.sv */
// Generic single-write, single-read memory with a registered read port.
// Self-contained; used for the sample stacks, descriptors and burst bits.
`timescale 1ns / 1ps
module pwo_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

/* hdl/pwo_rem.sv */
// Restoring remainder unit, one dividend bit per cycle.
// Depends on pwo_pkg for its operand widths.
`timescale 1ns / 1ps
module pwo_rem (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [pwo_pkg::REM_NUM_W-1:0]  i_dividend,
    input  logic [pwo_pkg::REM_DEN_W-1:0]  i_divisor,
    output logic                           o_done,
    output logic [pwo_pkg::REM_DEN_W-1:0]  o_rem
);
    import pwo_pkg::*;

    localparam int CNT_W = $clog2(REM_NUM_W);

    logic                 r_busy, n_busy;
    logic                 r_done, n_done;
    logic [CNT_W-1:0]     r_cnt, n_cnt;
    logic [REM_DEN_W-1:0] r_rem, n_rem;
    logic [REM_NUM_W-1:0] r_shift, n_shift;
    logic [REM_DEN_W-1:0] r_div, n_div;
    logic [REM_DEN_W:0]   rem_sh;
    logic                 ge;

    // One restoring step: shift in the next dividend bit, subtract if it fits.
    always_comb begin
        rem_sh  = {r_rem, r_shift[REM_NUM_W-1]};
        ge      = rem_sh >= {1'b0, r_div};
        n_busy  = r_busy;
        n_done  = 1'b0;
        n_cnt   = r_cnt;
        n_rem   = r_rem;
        n_shift = r_shift;
        n_div   = r_div;
        if (i_start) begin
            n_busy  = 1'b1;
            n_cnt   = '0;
            n_rem   = '0;
            n_shift = i_dividend;
            n_div   = i_divisor;
        end else if (r_busy) begin
            n_rem   = ge ? REM_DEN_W'(rem_sh - {1'b0, r_div}) : REM_DEN_W'(rem_sh);
            n_shift = {r_shift[REM_NUM_W-2:0], 1'b0};
            n_cnt   = r_cnt + 1'b1;
            if (r_cnt == CNT_W'(REM_NUM_W - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_rem   <= n_rem;
        r_shift <= n_shift;
        r_div   <= n_div;
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

/* hdl/pwo_ctrl.sv */
// Sequencer of the oscillator: burst lookup, then table reads and mixing for sounded ticks.
// Depends on pwo_pkg and the assertion macros header.
`timescale 1ns / 1ps
`include "pulsar_wavetable_oscillator_defines.svh"
module pwo_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  pwo_pkg::t_status i_status,
    output logic             o_in_ready,
    output pwo_pkg::t_cmd    o_cmd
);
    import pwo_pkg::*;

    t_state r_state, n_state;
    logic   r_side, n_side;
    logic   r_second, n_second;
    logic   r_outer, n_outer;

    // Next state.
    always_comb begin
        n_state  = r_state;
        n_side   = r_side;
        n_second = r_second;
        n_outer  = r_outer;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid && i_status.is_tick) begin
                    n_state  = S_START;
                    n_side   = 1'b0;
                    n_second = 1'b0;
                    n_outer  = 1'b0;
                end
            end
            S_START:  n_state = i_status.blen_zero ? S_BCHK : S_BDIV;
            S_BDIV:   if (i_status.rem_done) n_state = S_BRD;
            S_BRD:    n_state = S_BCHK;
            S_BCHK:   n_state = S_BDEC;
            S_BDEC:   n_state = i_status.sounded ? S_SIDE : S_FIN;
            S_SIDE: begin
                n_second = 1'b0;
                n_outer  = 1'b0;
                if (i_status.cnt_zero) begin
                    n_state = r_side ? S_FIN : S_SDONE;
                end else if (i_status.cnt_one) begin
                    n_state = S_DLATCH;
                end else begin
                    n_state = S_MORPH;
                end
            end
            S_MORPH:  n_state = S_MSAVE;
            S_MSAVE:  n_state = S_DREAD;
            S_DREAD:  n_state = S_DLATCH;
            S_DLATCH: n_state = S_PMUL;
            S_PMUL:   n_state = S_PSAVE;
            S_PSAVE:  n_state = S_ADIV;
            S_ADIV:   if (i_status.rem_done) n_state = S_SRDA;
            S_SRDA:   n_state = S_SRDB;
            S_SRDB:   n_state = S_SLB;
            S_SLB:    n_state = S_MIXA;
            S_MIXA:   n_state = S_MIXB;
            S_MIXB:   n_state = S_MIXC;
            S_MIXC: begin
                if (r_outer || i_status.cnt_one) begin
                    n_state = S_SDONE;
                end else if (!r_second) begin
                    n_second = 1'b1;
                    n_state  = S_DREAD;
                end else begin
                    n_outer = 1'b1;
                    n_state = S_OUTER;
                end
            end
            S_OUTER:  n_state = S_MIXA;
            S_SDONE: begin
                if (!r_side) begin
                    n_side  = 1'b1;
                    n_state = S_SIDE;
                end else begin
                    n_state = S_WMUL;
                end
            end
            S_WMUL:   n_state = S_WSAT;
            S_WSAT:   n_state = S_FIN;
            S_FIN:    if (i_status.out_free) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    // Datapath commands.
    always_comb begin
        o_cmd.side   = r_side;
        o_cmd.second = r_second;
        o_in_ready   = (r_state == S_IDLE);
        case (r_state)
            S_IDLE:   o_cmd.op = OP_IDLE;
            S_START:  o_cmd.op = OP_START;
            S_BRD:    o_cmd.op = OP_BREAD;
            S_BCHK:   o_cmd.op = OP_BCHK;
            S_MORPH:  o_cmd.op = OP_MORPH;
            S_MSAVE:  o_cmd.op = OP_MSAVE;
            S_DREAD:  o_cmd.op = OP_DREAD;
            S_DLATCH: o_cmd.op = OP_DLATCH;
            S_PMUL:   o_cmd.op = OP_PMUL;
            S_PSAVE:  o_cmd.op = OP_PSAVE;
            S_SRDA:   o_cmd.op = OP_SREADA;
            S_SRDB:   o_cmd.op = OP_SREADB;
            S_SLB:    o_cmd.op = OP_SLATCHB;
            S_MIXA:   o_cmd.op = OP_MIXA;
            S_MIXB:   o_cmd.op = OP_MIXB;
            S_MIXC:   o_cmd.op = OP_MIXC;
            S_OUTER:  o_cmd.op = OP_OUTER;
            S_SDONE:  o_cmd.op = OP_SDONE;
            S_WMUL:   o_cmd.op = OP_WMUL;
            S_WSAT:   o_cmd.op = OP_WSAT;
            S_FIN:    o_cmd.op = i_status.out_free ? OP_FIN : OP_NONE;
            default:  o_cmd.op = OP_NONE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_side   <= 1'b0;
            r_second <= 1'b0;
            r_outer  <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_side   <= n_side;
            r_second <= n_second;
            r_outer  <= n_outer;
        end
    end

    // A finished tick returns to idle once the output register is free.
    `PWO_ASSERT_NEXT(a_fin_to_idle, i_clk, i_rst_n, (r_state == S_FIN) && i_status.out_free, r_state == S_IDLE)
    // An accepted tick always starts the sequence.
    `PWO_ASSERT_NEXT(a_tick_starts, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid && i_status.is_tick, r_state == S_START)
    // A silenced pulse skips all table work.
    `PWO_ASSERT_NEXT(a_silent_skip, i_clk, i_rst_n, (r_state == S_BDEC) && !i_status.sounded, r_state == S_FIN)

endmodule

/* hdl/pwo_dpath.sv */
// Datapath of the oscillator: registers, stacks, descriptor and burst memories,
// the shared multiplier and remainder unit. Depends on pwo_pkg, pwo_ram, pwo_rem.
`timescale 1ns / 1ps
module pwo_dpath #(
    parameter int STACK_DEPTH = 4096,
    parameter int MAX_TABLES  = 8,
    parameter int BURST_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  pwo_pkg::t_cmd      i_cmd,
    output pwo_pkg::t_status   o_status,
    input  logic               i_in_valid,
    input  pwo_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pwo_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata
);
    import pwo_pkg::*;

    localparam int SA_W = $clog2(STACK_DEPTH);
    localparam int TI_W = (MAX_TABLES > 1) ? $clog2(MAX_TABLES) : 1;
    localparam int BA_W = $clog2(BURST_DEPTH);

    // Configuration registers.
    logic [31:0] r_phase_step, r_wave_mstep, r_win_mstep, r_noise_seed;
    logic [16:0] r_saturation;
    logic [3:0]  r_wave_cnt, r_win_cnt;
    logic [10:0] r_burst_len;

    // Oscillator state.
    logic [31:0] r_phase, r_wave_morph, r_win_morph, r_lfsr;
    logic [10:0] r_burst_pos;
    logic [12:0] r_wave_total, r_win_total;

    // Working registers of one tick.
    logic                r_silenced, r_sounded;
    logic [10:0]         r_bmod;
    logic signed [50:0]  r_prod, r_acc;
    logic [15:0]         r_ft, r_mf;
    logic [3:0]          r_ti;
    logic [11:0]         r_off;
    logic [12:0]         r_len, r_ai;
    logic signed [15:0]  r_ma, r_mb, r_v0, r_v1, r_mres, r_s, r_w;
    logic                r_out_valid;
    t_out_item           r_out;

    // Combinational helpers.
    logic               accept, cfg_wr;
    t_reg_idx           cfg_idx;
    logic [3:0]         cnt_raw, cnt;
    logic [12:0]        tot_raw, totc;
    logic [31:0]        morph;
    logic [10:0]        blen;
    logic [3:0]         ti_j;
    logic [12:0]        bi;
    logic [24:0]        wave_desc_q, win_desc_q, desc_q;
    logic [15:0]        wave_stack_q, win_stack_q, stack_q;
    logic [0:0]         burst_q;
    logic [SA_W-1:0]    stack_raddr;
    logic               wave_we, win_we, wdesc_we, ndesc_we, burst_we;
    logic signed [32:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [50:0] mul_p;
    logic signed [50:0] mix_sum;
    logic signed [35:0] wq;
    logic signed [15:0] wsat;
    logic [31:0]        lfsr_next;
    logic [32:0]        phase_sum;
    logic               edge_flag;
    logic [11:0]        bnext;
    logic               rem_start, rem_done;
    logic [REM_NUM_W-1:0] rem_num;
    logic [REM_DEN_W-1:0] rem_den, rem_q;

    assign accept  = i_in_valid && (i_cmd.op == OP_IDLE);
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_idx = t_reg_idx'(paddr[4:2]);

    // Per-side selection of count, total, morph and read data; clamping; next indices.
    always_comb begin
        cnt_raw = i_cmd.side ? r_win_cnt : r_wave_cnt;
        cnt     = (int'(cnt_raw) > MAX_TABLES) ? 4'(MAX_TABLES) : cnt_raw;
        tot_raw = i_cmd.side ? r_win_total : r_wave_total;
        if (tot_raw == 13'd0) begin
            totc = 13'd1;
        end else if (int'(tot_raw) > STACK_DEPTH) begin
            totc = 13'(STACK_DEPTH);
        end else begin
            totc = tot_raw;
        end
        morph   = i_cmd.side ? r_win_morph : r_wave_morph;
        desc_q  = i_cmd.side ? win_desc_q : wave_desc_q;
        stack_q = i_cmd.side ? win_stack_q : wave_stack_q;
        blen    = (int'(r_burst_len) > BURST_DEPTH) ? 11'(BURST_DEPTH) : r_burst_len;
        ti_j    = ((r_ti + 4'd1) == cnt) ? 4'd0 : r_ti + 4'd1;
        bi      = ((r_ai + 13'd1) == totc) ? 13'd0 : r_ai + 13'd1;
    end

    // Memory write strobes from load items.
    assign wave_we  = accept && (i_in_data.kind == KIND_WAVE_SAMPLE)
                      && (int'(i_in_data.address) < STACK_DEPTH);
    assign win_we   = accept && (i_in_data.kind == KIND_WIN_SAMPLE)
                      && (int'(i_in_data.address) < STACK_DEPTH);
    assign wdesc_we = accept && (i_in_data.kind == KIND_WAVE_DESC)
                      && (int'(i_in_data.address) < MAX_TABLES);
    assign ndesc_we = accept && (i_in_data.kind == KIND_WIN_DESC)
                      && (int'(i_in_data.address) < MAX_TABLES);
    assign burst_we = accept && (i_in_data.kind == KIND_BURST)
                      && (int'(i_in_data.address) < BURST_DEPTH);

    assign stack_raddr = (i_cmd.op == OP_SREADB) ? SA_W'(bi) : SA_W'(rem_q);

    pwo_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_wave_stack (
        .i_clk(i_clk), .i_we(wave_we), .i_waddr(SA_W'(i_in_data.address)),
        .i_wdata(i_in_data.value), .i_raddr(stack_raddr), .o_rdata(wave_stack_q)
    );
    pwo_ram #(.WIDTH(16), .DEPTH(STACK_DEPTH)) u_win_stack (
        .i_clk(i_clk), .i_we(win_we), .i_waddr(SA_W'(i_in_data.address)),
        .i_wdata(i_in_data.value), .i_raddr(stack_raddr), .o_rdata(win_stack_q)
    );
    pwo_ram #(.WIDTH(25), .DEPTH(MAX_TABLES)) u_wave_desc (
        .i_clk(i_clk), .i_we(wdesc_we), .i_waddr(TI_W'(i_in_data.address)),
        .i_wdata({i_in_data.onset, i_in_data.length}),
        .i_raddr(TI_W'(i_cmd.second ? ti_j : r_ti)), .o_rdata(wave_desc_q)
    );
    pwo_ram #(.WIDTH(25), .DEPTH(MAX_TABLES)) u_win_desc (
        .i_clk(i_clk), .i_we(ndesc_we), .i_waddr(TI_W'(i_in_data.address)),
        .i_wdata({i_in_data.onset, i_in_data.length}),
        .i_raddr(TI_W'(i_cmd.second ? ti_j : r_ti)), .o_rdata(win_desc_q)
    );
    pwo_ram #(.WIDTH(1), .DEPTH(BURST_DEPTH)) u_burst (
        .i_clk(i_clk), .i_we(burst_we), .i_waddr(BA_W'(i_in_data.address)),
        .i_wdata(i_in_data.value[0]), .i_raddr(BA_W'(rem_q)), .o_rdata(burst_q)
    );

    // Shared remainder unit: burst position modulo length, stack index modulo total.
    assign rem_start = ((i_cmd.op == OP_START) && (blen != 11'd0)) || (i_cmd.op == OP_PSAVE);
    assign rem_num   = (i_cmd.op == OP_START)
                       ? REM_NUM_W'(r_burst_pos)
                       : REM_NUM_W'({1'b0, r_prod[44:32]}) + REM_NUM_W'(r_off);
    assign rem_den   = (i_cmd.op == OP_START) ? REM_DEN_W'(blen) : totc;

    pwo_rem u_rem (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(rem_start),
        .i_dividend(rem_num), .i_divisor(rem_den), .o_done(rem_done), .o_rem(rem_q)
    );

    // Shared multiplier operand selection.
    always_comb begin
        case (i_cmd.op)
            OP_MORPH: begin
                mul_a = {1'b0, morph};
                mul_b = {14'd0, cnt};
            end
            OP_PMUL: begin
                mul_a = {1'b0, r_phase};
                mul_b = {5'd0, r_len};
            end
            OP_MIXA: begin
                mul_a = {{17{r_ma[15]}}, r_ma};
                mul_b = {1'b0, SAT_ALWAYS - {1'b0, r_mf}};
            end
            OP_MIXB: begin
                mul_a = {{17{r_mb[15]}}, r_mb};
                mul_b = {2'b0, r_mf};
            end
            OP_WMUL: begin
                mul_a = {{17{r_s[15]}}, r_s};
                mul_b = {{2{r_w[15]}}, r_w};
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign mul_p = mul_a * mul_b;

    // Interpolation sum, window product scaling and saturation.
    always_comb begin
        mix_sum = r_acc + r_prod;
        wq      = r_prod[50:15];
        if (wq > 36'sd32767) begin
            wsat = SMAX;
        end else if (wq < -36'sd32768) begin
            wsat = SMIN;
        end else begin
            wsat = wq[15:0];
        end
    end

    // LFSR step, phase advance and burst position advance.
    always_comb begin
        lfsr_next = {1'b0, r_lfsr[31:1]} ^ (r_lfsr[0] ? LFSR_MASK : 32'd0);
        phase_sum = {1'b0, r_phase} + {1'b0, r_phase_step};
        edge_flag = !r_phase_step[31] && phase_sum[32];
        bnext     = {1'b0, r_bmod} + {11'd0, edge_flag};
    end

    // Configuration, oscillator state and output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase_step <= RST_PHASE_STEP;
            r_wave_mstep <= RST_MORPH_STEP;
            r_win_mstep  <= RST_MORPH_STEP;
            r_saturation <= SAT_ALWAYS;
            r_wave_cnt   <= '0;
            r_win_cnt    <= '0;
            r_burst_len  <= '0;
            r_noise_seed <= RST_SEED;
            r_lfsr       <= RST_SEED;
            r_phase      <= '0;
            r_wave_morph <= '0;
            r_win_morph  <= '0;
            r_burst_pos  <= '0;
            r_wave_total <= 13'd1;
            r_win_total  <= 13'd1;
            r_out_valid  <= 1'b0;
        end else begin
            if (cfg_wr) begin
                case (cfg_idx)
                    REG_PHASE_STEP:   r_phase_step <= pwdata;
                    REG_WAVE_MSTEP:   r_wave_mstep <= pwdata;
                    REG_WIN_MSTEP:    r_win_mstep  <= pwdata;
                    REG_SATURATION:   r_saturation <= pwdata[16:0];
                    REG_WAVE_COUNT:   r_wave_cnt   <= pwdata[3:0];
                    REG_WIN_COUNT:    r_win_cnt    <= pwdata[3:0];
                    REG_BURST_LENGTH: r_burst_len  <= pwdata[10:0];
                    REG_NOISE_SEED: begin
                        r_noise_seed <= pwdata;
                        r_lfsr       <= (pwdata == 32'd0) ? 32'd1 : pwdata;
                    end
                    default: ;
                endcase
            end
            if (accept && (i_in_data.kind == KIND_WAVE_TOTAL)) begin
                r_wave_total <= i_in_data.length;
            end
            if (accept && (i_in_data.kind == KIND_WIN_TOTAL)) begin
                r_win_total <= i_in_data.length;
            end
            if ((i_cmd.op == OP_START) && (r_saturation < SAT_ALWAYS)) begin
                r_lfsr <= lfsr_next;
            end
            if (r_out_valid && i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == OP_FIN) begin
                r_phase      <= r_phase + r_phase_step;
                r_wave_morph <= r_wave_morph + r_wave_mstep;
                r_win_morph  <= r_win_morph + r_win_mstep;
                if (blen != 11'd0) begin
                    r_burst_pos <= (bnext == {1'b0, blen}) ? 11'd0 : bnext[10:0];
                end
                r_out_valid <= 1'b1;
            end
        end
    end

    // Working registers of the tick sequence.
    always_ff @(posedge i_clk) begin
        case (i_cmd.op)
            OP_START: begin
                r_silenced <= (r_saturation < SAT_ALWAYS)
                              && ({1'b0, lfsr_next[31:16]} > r_saturation);
            end
            OP_BREAD:  r_bmod <= 11'(rem_q);
            OP_BCHK:   r_sounded <= ((blen == 11'd0) || burst_q[0]) && !r_silenced;
            OP_MORPH:  r_prod <= mul_p;
            OP_MSAVE: begin
                r_ti <= r_prod[35:32];
                r_ft <= r_prod[31:16];
            end
            OP_DLATCH: begin
                if (cnt == 4'd1) begin
                    r_off <= '0;
                    r_len <= totc;
                end else begin
                    r_off <= desc_q[24:13];
                    r_len <= (desc_q[12:0] == 13'd0) ? 13'd1 : desc_q[12:0];
                end
            end
            OP_PMUL:    r_prod <= mul_p;
            OP_PSAVE:   r_mf <= r_prod[31:16];
            OP_SREADA:  r_ai <= rem_q;
            OP_SREADB:  r_ma <= stack_q;
            OP_SLATCHB: r_mb <= stack_q;
            OP_MIXA:    r_prod <= mul_p;
            OP_MIXB: begin
                r_acc  <= r_prod;
                r_prod <= mul_p;
            end
            OP_MIXC: begin
                r_mres <= mix_sum[31:16];
                if (i_cmd.second) begin
                    r_v1 <= mix_sum[31:16];
                end else begin
                    r_v0 <= mix_sum[31:16];
                end
            end
            OP_OUTER: begin
                r_ma <= r_v0;
                r_mb <= r_v1;
                r_mf <= r_ft;
            end
            OP_SDONE: begin
                if (i_cmd.side) begin
                    r_w <= r_mres;
                end else begin
                    r_s <= (cnt == 4'd0) ? SMAX : r_mres;
                end
            end
            OP_WMUL:   r_prod <= mul_p;
            OP_WSAT:   r_s <= wsat;
            OP_FIN: begin
                r_out.sample        <= r_sounded ? r_s : 16'sd0;
                r_out.pulse_edge    <= edge_flag;
                r_out.pulse_sounded <= r_sounded;
            end
            default: ;
        endcase
    end

    // Register read-back.
    always_comb begin
        case (cfg_idx)
            REG_PHASE_STEP:   prdata = r_phase_step;
            REG_WAVE_MSTEP:   prdata = r_wave_mstep;
            REG_WIN_MSTEP:    prdata = r_win_mstep;
            REG_SATURATION:   prdata = {15'd0, r_saturation};
            REG_WAVE_COUNT:   prdata = {28'd0, r_wave_cnt};
            REG_WIN_COUNT:    prdata = {28'd0, r_win_cnt};
            REG_BURST_LENGTH: prdata = {21'd0, r_burst_len};
            REG_NOISE_SEED:   prdata = r_noise_seed;
            default:          prdata = '0;
        endcase
    end

    // Status toward the sequencer.
    always_comb begin
        o_status.is_tick   = (i_in_data.kind == KIND_TICK);
        o_status.rem_done  = rem_done;
        o_status.blen_zero = (blen == 11'd0);
        o_status.sounded   = r_sounded;
        o_status.cnt_zero  = (cnt == 4'd0);
        o_status.cnt_one   = (cnt == 4'd1);
        o_status.out_free  = !r_out_valid || i_out_ready;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hdl/pulsar_wavetable_oscillator.sv */
// Pulsar wavetable oscillator top level: sequencer plus datapath.
// Depends on pwo_pkg, pwo_ctrl and pwo_dpath.
//
// Usage: load items (sample, descriptor, burst bit and total writes) arrive on the
// input channel and are written in the cycle of their transfer; the block is ready
// again on the next cycle. A tick item produces one result on the output channel.
// A tick is shortest for a silenced pulse with no burst table and longest for
// two multi-table sides. Its duration is set by the shared remainder unit,
// which runs for each stack index and for the burst lookup, and by the one
// shared multiplier that serves table select, position, interpolation and window.
// One tick is in work at a time; the next input is taken once it is finished.
// The result sits in an output register, so a stalled receiver only holds the
// block when the following tick completes; load items are still taken meanwhile.
// Reset (synchronous, active low) restores the register defaults, clears the
// phase and morph accumulators and burst position, reloads the noise LFSR and
// sets both stack totals to one; stacks, descriptors and burst bits keep their
// contents and must be written before use. The user must write registers over the
// APB port only while no tick is in flight; the block itself does not enforce it.
`timescale 1ns / 1ps
module pulsar_wavetable_oscillator #(
    parameter int STACK_DEPTH = 4096,
    parameter int MAX_TABLES  = 8,
    parameter int BURST_DEPTH = 1024
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  pwo_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output pwo_pkg::t_out_item o_out_data,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);
    import pwo_pkg::*;

    t_cmd    cmd;
    t_status status;

    assign pready = 1'b1;

    // Sequencer.
    pwo_ctrl u_ctrl (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in_valid(i_in_valid),
        .i_status(status), .o_in_ready(o_in_ready), .o_cmd(cmd)
    );

    // Datapath with memories and configuration registers.
    pwo_dpath #(
        .STACK_DEPTH(STACK_DEPTH), .MAX_TABLES(MAX_TABLES), .BURST_DEPTH(BURST_DEPTH)
    ) u_dpath (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_cmd(cmd), .o_status(status),
        .i_in_valid(i_in_valid), .i_in_data(i_in_data),
        .o_out_valid(o_out_valid), .i_out_ready(i_out_ready), .o_out_data(o_out_data),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata)
    );

endmodule
